[rtl/anp_pkg.sv]
package anp_pkg;

    // Character codes the parser reacts to
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_X    = 8'h78;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_UF   = 8'h46;
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_LF   = 8'h66;

    // Digit decode result that marks a character that is no digit
    localparam logic [4:0] NOT_DIGIT = 5'd16;

    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_ZERO  = 5'b00010,
        PH_DEC   = 5'b00100,
        PH_HEX   = 5'b01000,
        PH_SKIP  = 5'b10000
    } phase_t;

    // Return the digit value, or NOT_DIGIT; letters count only in base sixteen
    function automatic logic [4:0] decode_digit(input logic [7:0] ch, input logic hex);
        logic [7:0] diff;
        begin
            diff = 8'h00;
            if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
            begin
                diff = ch - CHAR_ZERO;
                decode_digit = diff[4:0];
            end
            else if (hex && ch >= CHAR_UA && ch <= CHAR_UF)
            begin
                diff = ch - CHAR_UA + 8'd10;
                decode_digit = diff[4:0];
            end
            else if (hex && ch >= CHAR_LA && ch <= CHAR_LF)
            begin
                diff = ch - CHAR_LA + 8'd10;
                decode_digit = diff[4:0];
            end
            else
            begin
                decode_digit = NOT_DIGIT;
            end
        end
    endfunction

endpackage

[rtl/ascii_number_parser.sv]
// Channel | Handshake            | Word
// --------+----------------------+------------------------------------------
// input   | in_valid / in_ready  | char_code
// output  | out_valid / out_ready| number_value, consumed_count, was_hex
//
// One character per cycle while the result side has room; a character waits in the input
// register and its result word, if any, is loaded from there into the result register
// once that register is free. The pacing is set by the combinational Horner
// update (shift-add for base ten, shift for base sixteen) on the accumulator.
// Reset clears the parse state and both valid flags; the next string begins fresh.
// A held result word stalls the input register, which in turn lowers in_ready.
module ascii_number_parser
    import anp_pkg::*;
#(
    parameter int MAX_CHARS = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] number_value,
    output logic [7:0]  consumed_count,
    output logic        was_hex
);

    localparam int         CountLimitInt = (MAX_CHARS < 255) ? MAX_CHARS : 255;
    localparam logic [7:0] COUNT_LIMIT   = 8'(CountLimitInt);

    logic        char_valid_reg;
    logic [7:0]  char_reg;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] value_reg;
    logic [7:0]  cnt_out_reg;
    logic        hex_out_reg;

    logic        consume;
    logic        emit;
    logic [31:0] emit_value;
    logic [7:0]  emit_count;
    logic        emit_hex;
    logic [4:0]  digit;
    logic [7:0]  count_inc;
    logic [31:0] acc_dec;
    logic [31:0] acc_hex;

    // Advance the character register whenever the result side has room
    assign consume  = char_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !char_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            char_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= char_code;
        end
    end

    // Decode the digit and form both Horner updates
    assign digit     = decode_digit(char_reg, phase_reg == PH_HEX);
    assign count_inc = (count_reg < COUNT_LIMIT) ? count_reg + 8'd1 : COUNT_LIMIT;
    assign acc_dec   = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0}
                       + {28'd0, digit[3:0]};
    assign acc_hex   = {acc_reg[27:0], digit[3:0]};

    // Step the parse state for one character
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        emit       = 1'b0;
        emit_value = acc_reg;
        emit_count = count_reg;
        emit_hex   = 1'b0;
        unique case (phase_reg)
            PH_START:
            begin
                if (char_reg == CHAR_ZERO)
                begin
                    phase_next = PH_ZERO;
                    acc_next   = 32'd0;
                    count_next = 8'd1;
                end
                else if (digit != NOT_DIGIT)
                begin
                    phase_next = PH_DEC;
                    acc_next   = {28'd0, digit[3:0]};
                    count_next = 8'd1;
                end
                else
                begin
                    emit       = 1'b1;
                    emit_value = 32'd0;
                    emit_count = 8'd0;
                end
            end
            PH_ZERO:
            begin
                if (char_reg == CHAR_X)
                begin
                    phase_next = PH_HEX;
                    acc_next   = 32'd0;
                    count_next = count_inc;
                end
                else if (digit != NOT_DIGIT)
                begin
                    phase_next = PH_DEC;
                    acc_next   = {28'd0, digit[3:0]};
                    count_next = count_inc;
                end
                else
                begin
                    emit       = 1'b1;
                    emit_value = 32'd0;
                end
            end
            PH_DEC:
            begin
                if (digit != NOT_DIGIT)
                begin
                    acc_next   = acc_dec;
                    count_next = count_inc;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            PH_HEX:
            begin
                if (digit != NOT_DIGIT)
                begin
                    acc_next   = acc_hex;
                    count_next = count_inc;
                end
                else
                begin
                    emit     = 1'b1;
                    emit_hex = 1'b1;
                end
            end
            PH_SKIP:
            begin
                if (char_reg == CHAR_NUL)
                begin
                    phase_next = PH_START;
                    acc_next   = 32'd0;
                    count_next = 8'd0;
                end
            end
            default:
            begin
                phase_next = PH_START;
                acc_next   = 32'd0;
                count_next = 8'd0;
            end
        endcase
        // Drop the accumulation once the word is out
        if (emit)
        begin
            phase_next = (char_reg == CHAR_NUL) ? PH_START : PH_SKIP;
            acc_next   = 32'd0;
            count_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            acc_reg   <= 32'd0;
            count_reg <= 8'd0;
        end
        else if (consume)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

    // Hold the result word until it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (consume && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && emit)
        begin
            value_reg   <= emit_value;
            cnt_out_reg <= emit_count;
            hex_out_reg <= emit_hex;
        end
    end

    assign out_valid      = out_valid_reg;
    assign number_value   = value_reg;
    assign consumed_count = cnt_out_reg;
    assign was_hex        = hex_out_reg;

endmodule

[bench/tb_top.sv]
module tb_top
    import anp_pkg::*;
;

    localparam int COUNT_CAP   = 255;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_CHARS = 220;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  count;
        logic        hex;
    } parsed_word_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  char_code = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] number_value;
    logic [7:0]  consumed_count;
    logic        was_hex;

    // Expected result words, oldest first
    parsed_word_t expected_words[$];

    // Shadow copy of the parser state
    phase_t      exp_phase = PH_START;
    logic [31:0] exp_acc   = '0;
    logic [7:0]  exp_count = '0;

    int  error_count = 0;
    int  cycle_count = 0;
    int  chars_sent  = 0;
    int  stall_left  = 0;
    bit  quiet       = 1'b0;

    ascii_number_parser dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_code      (char_code),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .number_value   (number_value),
        .consumed_count (consumed_count),
        .was_hex        (was_hex)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up after a generous number of cycles
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Return the digit weight of a character, or -1 if it is no digit in that base
    function automatic int digit_weight(input logic [7:0] c, input bit base16);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            return int'(c) - int'(CHAR_ZERO);
        if (base16 && c >= CHAR_UA && c <= CHAR_UF)
            return int'(c) - int'(CHAR_UA) + 10;
        if (base16 && c >= CHAR_LA && c <= CHAR_LF)
            return int'(c) - int'(CHAR_LA) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] count_next(input logic [7:0] cnt);
        return (int'(cnt) < COUNT_CAP) ? cnt + 8'd1 : 8'(COUNT_CAP);
    endfunction

    // Close the current string: queue its word and restart or skip
    function automatic void close_string(input logic [31:0] val, input logic [7:0] cnt,
                                         input logic hex, input logic [7:0] c);
        parsed_word_t w;
        w.value = val;
        w.count = cnt;
        w.hex   = hex;
        expected_words.push_back(w);
        exp_phase = (c == CHAR_NUL) ? PH_START : PH_SKIP;
        exp_acc   = '0;
        exp_count = '0;
    endfunction

    // Advance the shadow parser by one accepted character
    function automatic void parse_char(input logic [7:0] c);
        int d;
        case (exp_phase)
            PH_START:
            begin
                d = digit_weight(c, 1'b0);
                if (c == CHAR_ZERO)
                begin
                    exp_phase = PH_ZERO;
                    exp_acc   = '0;
                    exp_count = count_next(8'd0);
                end
                else if (d >= 0)
                begin
                    exp_phase = PH_DEC;
                    exp_acc   = 32'(d);
                    exp_count = count_next(8'd0);
                end
                else
                    close_string(32'd0, 8'd0, 1'b0, c);
            end
            PH_ZERO:
            begin
                d = digit_weight(c, 1'b0);
                if (c == CHAR_X)
                begin
                    exp_phase = PH_HEX;
                    exp_acc   = '0;
                    exp_count = count_next(exp_count);
                end
                else if (d >= 0)
                begin
                    exp_phase = PH_DEC;
                    exp_acc   = 32'(d);
                    exp_count = count_next(exp_count);
                end
                else
                    close_string(32'd0, exp_count, 1'b0, c);
            end
            PH_DEC:
            begin
                d = digit_weight(c, 1'b0);
                if (d >= 0)
                begin
                    exp_acc   = exp_acc * 32'd10 + 32'(d);
                    exp_count = count_next(exp_count);
                end
                else
                    close_string(exp_acc, exp_count, 1'b0, c);
            end
            PH_HEX:
            begin
                d = digit_weight(c, 1'b1);
                if (d >= 0)
                begin
                    exp_acc   = exp_acc * 32'd16 + 32'(d);
                    exp_count = count_next(exp_count);
                end
                else
                    close_string(exp_acc, exp_count, 1'b1, c);
            end
            default:
            begin
                if (c == CHAR_NUL)
                begin
                    exp_phase = PH_START;
                    exp_acc   = '0;
                    exp_count = '0;
                end
            end
        endcase
    endfunction

    // Offer one character, wait for it to be taken, then predict
    task automatic send_char(input logic [7:0] c);
        if (!quiet && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        parse_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input bit terminate);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        if (terminate)
            send_char(CHAR_NUL);
    endtask

    // Drop valid and hold until every expected word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Pick a random hex digit in either letter case
    function automatic logic [7:0] random_hex_char();
        case ($urandom_range(0, 2))
            0: return CHAR_ZERO + 8'($urandom_range(0, 9));
            1: return CHAR_UA + 8'($urandom_range(0, 5));
            default: return CHAR_LA + 8'($urandom_range(0, 5));
        endcase
    endfunction

    task automatic test_directed_cases();
        string cases[$];
        cases = '{"", "A", "0", "0z", "0x", "0xg", "0X1", "007", "12;34",
                  "4294967295", "4294967296", "0xFFFFFFFF", "0x1aBcDeF0",
                  "0x0x5", "0x123456789"};
        foreach (cases[i])
            send_text(cases[i], 1'b1);
        // Hold high bytes in the skip phase
        send_text("9!", 1'b0);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(CHAR_NUL);
        wait_drained();
    endtask

    // Run counts past the cap in both bases
    task automatic test_count_saturation();
        repeat (258)
            send_char(CHAR_ZERO + 8'd7);
        send_char(CHAR_NUL);
        send_text("0x", 1'b0);
        repeat (256)
            send_char(random_hex_char());
        send_char(CHAR_NUL);
        wait_drained();
    endtask

    // Hold off the receiver while short strings keep coming, so the input stalls
    task automatic test_backpressure();
        stall_left <= 80;
        repeat (40)
        begin
            send_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
            send_char(CHAR_NUL);
        end
        wait_drained();
    endtask

    task automatic send_random_string();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        if (kind <= 3)
        begin
            n = $urandom_range(1, 12);
            repeat (n)
                send_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        else if (kind <= 6)
        begin
            send_text("0x", 1'b0);
            n = $urandom_range(0, 10);
            repeat (n)
                send_char(random_hex_char());
        end
        else if (kind == 7)
        begin
            case ($urandom_range(0, 3))
                0: send_text("0", 1'b0);
                1: send_text("0X", 1'b0);
                2: send_text("0x", 1'b0);
                default: send_char(8'($urandom_range(0, 255)));
            endcase
        end
        else
        begin
            n = $urandom_range(1, 8);
            repeat (n)
                send_char(8'($urandom_range(0, 255)));
        end
        // Append junk now and then before any terminator
        if ($urandom_range(0, 9) >= 7)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                send_char(8'($urandom_range(0, 255)));
        end
        if (kind < 9)
            send_char(CHAR_NUL);
    endtask

    task automatic test_random_strings();
        int start;
        start = chars_sent;
        quiet = 1'b1;
        while (chars_sent - start < RANDOM_CHARS)
        begin
            if (chars_sent - start > 100)
                quiet = 1'b0;
            send_random_string();
        end
        send_char(CHAR_NUL);
        wait_drained();
    endtask

    // Drive out_ready: long hold-off when requested, random idles otherwise unless quiet
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
            out_ready <= quiet || ($urandom_range(99) >= 6);
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin : check_word
        parsed_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word value %h count %0d hex %b",
                         $time, number_value, consumed_count, was_hex);
                error_count = error_count + 1;
            end
            else
            begin
                want = expected_words.pop_front();
                if (number_value !== want.value)
                begin
                    $display("%0t: number_value expected %h actual %h",
                             $time, want.value, number_value);
                    error_count = error_count + 1;
                end
                if (consumed_count !== want.count)
                begin
                    $display("%0t: consumed_count expected %0d actual %0d",
                             $time, want.count, consumed_count);
                    error_count = error_count + 1;
                end
                if (was_hex !== want.hex)
                begin
                    $display("%0t: was_hex expected %b actual %b",
                             $time, want.hex, was_hex);
                    error_count = error_count + 1;
                end
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_count_saturation();
        test_backpressure();
        test_random_strings();
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
